[hw/rtl/assert_macros.svh]
// assertion helpers, sampled on clk; CHK_ASSERT uses rst as the disable term
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/pmpc_pkg.sv]
package pmpc_pkg;

  localparam int unsigned CFG_W = 13;

  localparam logic [7:0] ACK_BYTE = 8'hFA;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic CFG_FRAME_WIDTH = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_DX = 2'd1,
    PH_DY = 2'd2
  } phase_t;

  typedef struct packed {
    logic done;
    logic [7:0] status;
    logic [7:0] dx;
    logic [7:0] dy;
  } packet_t;

endpackage

[hw/rtl/ps2_mouse_packet_cursor_unit.sv]
// PS/2 mouse packet decoder with a clamped cursor.
// Input channel: rx_byte with in_valid / in_stall, one mouse byte per request.
// Output channel: cursor_x, cursor_y and the three buttons with out_valid /
// out_stall, one request per complete three-byte packet.
// Until the acknowledge byte 0xFA is seen every byte is dropped; then bytes
// are framed as status, x delta, y delta.
// Config: cfg_write, cfg_index (0 screen width, 1 screen height), cfg_data;
// write only while the block is idle.
// A packet's last byte goes through the input register, then the result
// register, before it shows on the outputs.
// Throughput: one byte per cycle while in_stall is low; the position update
// for a packet is combinational between the input and result registers.
// Reset (synchronous, rst high): unsynchronized, phase at status, screen
// 640x480, position at 320,240 (not the cursor ports), both registers empty.
// When the receiver stalls, the result holds; the block still takes bytes
// until a finished packet meets the full result register, then in_stall rises.
module ps2_mouse_packet_cursor_unit #(
  parameter int POS_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] rx_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [11:0] cursor_x,
  output logic [11:0] cursor_y,
  output logic left_button,
  output logic right_button,
  output logic middle_button,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic [pmpc_pkg::CFG_W-1:0] cfg_data
);
  import pmpc_pkg::*;

  localparam int PW = (POS_BITS > 10) ? POS_BITS : 10;
  localparam int W = ((PW > 13) ? PW : 13) + 2;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic r_valid;
  logic [7:0] r_byte;
  logic fire;

  logic [PW-1:0] pos_x;
  logic [PW-1:0] pos_y;
  logic [PW-1:0] pos_x_next;
  logic [PW-1:0] pos_y_next;

  packet_t pkt;
  logic signed [9:0] dx_ext;
  logic signed [9:0] dy_ext;
  logic signed [9:0] dy_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: frame_width <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fire = r_valid && (!pkt.done || !out_valid || !out_stall);
  assign in_stall = r_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!in_stall) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) r_byte <= rx_byte;
  end

  pmpc_framer u_framer (
    .clk(clk),
    .rst(rst),
    .take(fire),
    .rx_byte(r_byte),
    .pkt(pkt)
  );

  assign dx_ext = $signed({{2{pkt.status[4]}}, pkt.dx});
  assign dy_ext = $signed({{2{pkt.status[5]}}, pkt.dy});
  assign dy_neg = -dy_ext;

  pmpc_axis #(.POS_BITS(POS_BITS), .PW(PW), .W(W)) u_axis_x (
    .pos(pos_x),
    .delta(dx_ext),
    .size(frame_width),
    .pos_next(pos_x_next)
  );

  pmpc_axis #(.POS_BITS(POS_BITS), .PW(PW), .W(W)) u_axis_y (
    .pos(pos_y),
    .delta(dy_neg),
    .size(frame_height),
    .pos_next(pos_y_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= PW'(WIDTH_RESET >> 1);
      pos_y <= PW'(HEIGHT_RESET >> 1);
      out_valid <= 1'b0;
    end else if (fire && pkt.done) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pkt.done) begin
      cursor_x <= 12'(pos_x_next);
      cursor_y <= 12'(pos_y_next);
      left_button <= pkt.status[0];
      right_button <= pkt.status[1];
      middle_button <= pkt.status[2];
    end
  end

endmodule

[hw/rtl/pmpc_framer.sv]
module pmpc_framer (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  logic [7:0] rx_byte,
  output pmpc_pkg::packet_t pkt
);
  import pmpc_pkg::*;

  logic synced;
  phase_t phase;
  logic [7:0] status_hold;
  logic [7:0] dx_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      synced <= 1'b0;
      phase <= PH_STATUS;
      status_hold <= '0;
      dx_hold <= '0;
    end else if (take) begin
      if (!synced) begin
        if (rx_byte == ACK_BYTE) synced <= 1'b1;
      end else begin
        case (phase)
          PH_DX: begin
            dx_hold <= rx_byte;
            phase <= PH_DY;
          end
          PH_DY: begin
            phase <= PH_STATUS;
          end
          default: begin
            status_hold <= rx_byte;
            phase <= PH_DX;
          end
        endcase
      end
    end
  end

  always_comb begin
    pkt.done = synced && (phase == PH_DY);
    pkt.status = status_hold;
    pkt.dx = dx_hold;
    pkt.dy = rx_byte;
  end

endmodule

[hw/rtl/pmpc_axis.sv]
module pmpc_axis #(
  parameter int POS_BITS = 12,
  parameter int PW = 12,
  parameter int W = 15
) (
  input  logic [PW-1:0] pos,
  input  logic signed [9:0] delta,
  input  logic [pmpc_pkg::CFG_W-1:0] size,
  output logic [PW-1:0] pos_next
);
  import pmpc_pkg::*;

  logic signed [W-1:0] sum;
  logic [W-1:0] size_w;
  logic [W-1:0] cap;
  logic [W-1:0] lim;

  assign sum = $signed({{(W-PW){1'b0}}, pos}) + W'(delta);
  assign size_w = W'(size);
  assign cap = W'(1) << POS_BITS;

  always_comb begin
    lim = size_w;
    if (size_w == '0) lim = W'(1);
    if (lim > cap) lim = cap;
    if (sum[W-1]) begin
      pos_next = '0;
    end else if ($unsigned(sum) >= lim) begin
      pos_next = PW'(lim - W'(1));
    end else begin
      pos_next = PW'($unsigned(sum));
    end
  end

endmodule

[hw/rtl/pmpc_checker.sv]
`include "assert_macros.svh"

module pmpc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [11:0] cursor_x,
  input logic [11:0] cursor_y,
  input logic left_button,
  input logic right_button,
  input logic middle_button
);

  logic [26:0] out_payload;

  assign out_payload = {cursor_x, cursor_y, left_button, right_button, middle_button};

  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(out_payload);
  endproperty

  property p_result_source;
    $rose(out_valid) |-> $past(in_valid && !in_stall && !rst, 2);
  endproperty

  // a stalled result stays put
  `CHK_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

  // reset empties the result register
  `CHK_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // a new result needs a request taken by the input register before it
  `CHK_ASSERT(a_result_source, p_result_source, "result without request")

  // with the result register empty the input never stalls
  `CHK_ASSERT(a_no_idle_stall, !out_valid |-> !in_stall, "input stalled with empty output")

endmodule

bind ps2_mouse_packet_cursor_unit pmpc_checker u_pmpc_checker (.*);
